/* hw/rtl/gbn_pkg.sv */
package gbn_pkg;

   localparam int SEQ_SPACE    = 8;
   localparam int SEQ_W        = $clog2(SEQ_SPACE);
   localparam int PAYLOAD_BITS = 32;
   localparam int DATA_W       = 32;
   localparam int WIN_W        = 3;
   localparam int MAX_RESULTS  = 7;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

   // APB map: one 32-bit register per word
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_SIZE = '0;

   typedef enum logic [1:0] {
      KIND_SEND    = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      EV_NEW          = 3'd0,
      EV_RETX         = 3'd1,
      EV_REFUSED      = 3'd2,
      EV_ACK_TAKEN    = 3'd3,
      EV_ACK_CORRUPT  = 3'd4,
      EV_ACK_STALE    = 3'd5,
      EV_TIMEOUT_IDLE = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      TMR_NONE    = 2'd0,
      TMR_START   = 2'd1,
      TMR_STOP    = 2'd2,
      TMR_RESTART = 2'd3
   } timer_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [DATA_W-1:0] payload;
      logic [SEQ_W-1:0]  ack_number;
      logic              ack_intact;
   } req_type;

   typedef struct packed {
      logic [2:0]        event_res;
      logic [SEQ_W-1:0]  seq_out;
      logic [DATA_W-1:0] data_out;
      logic [1:0]        timer_command;
      logic              window_full;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic hold_load;
      logic step;
      logic retx_start;
      logic retx_emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       cnt_zero;
      logic       retx_last;
   } status_type;

endpackage

/* hw/rtl/gbn_ram.sv */
module gbn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/gbn_dp.sv */
module gbn_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  gbn_pkg::req_type                req_data,
   input  gbn_pkg::cmd_type                cmd,
   output gbn_pkg::status_type             status,
   output gbn_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gbn_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [gbn_pkg::CSR_DATA_W-1:0]  prdata
);

   logic [gbn_pkg::WIN_W-1:0] window_size_ff, window_size_in;
   logic [gbn_pkg::SEQ_W-1:0] base_ff, base_in;
   logic [gbn_pkg::SEQ_W-1:0] next_ff, next_in;
   logic [gbn_pkg::SEQ_W-1:0] idx_ff, idx_in;
   gbn_pkg::req_type          hold_ff, hold_in;
   gbn_pkg::rsp_type          rsp_ff, rsp_in;

   logic [gbn_pkg::SEQ_W-1:0] outstanding;
   logic [gbn_pkg::SEQ_W-1:0] ack_off;
   logic [gbn_pkg::SEQ_W-1:0] out_after;
   logic [gbn_pkg::SEQ_W-1:0] base_new, next_new;
   logic                      full_now;
   logic                      retx_last;
   logic                      cfg_we;
   gbn_pkg::rsp_type          step_rsp, retx_rsp;

   logic                             store_we, store_re;
   logic [gbn_pkg::SEQ_W-1:0]        store_raddr;
   logic [gbn_pkg::PAYLOAD_BITS-1:0] store_rdata;

   // config register
   assign cfg_we = psel & penable & pwrite
                 & (paddr[gbn_pkg::CSR_ADDR_W-1:2] == gbn_pkg::REG_WINDOW_SIZE);
   assign window_size_in = cfg_we ? pwdata[gbn_pkg::WIN_W-1:0] : window_size_ff;
   assign prdata = (paddr[gbn_pkg::CSR_ADDR_W-1:2] == gbn_pkg::REG_WINDOW_SIZE)
                 ? gbn_pkg::CSR_DATA_W'(window_size_ff) : '0;

   assign outstanding = gbn_pkg::SEQ_W'(next_ff - base_ff);
   assign full_now    = outstanding >= window_size_ff;
   assign ack_off     = gbn_pkg::SEQ_W'(hold_ff.ack_number - base_ff);
   assign retx_last   = (gbn_pkg::SEQ_W'(idx_ff + 1'b1) == outstanding)
                      || (idx_ff == gbn_pkg::SEQ_W'(gbn_pkg::MAX_RESULTS - 1));

   // single-beat result for send, ack and idle timeout
   always_comb begin
      base_new = base_ff;
      next_new = next_ff;
      store_we = 1'b0;
      step_rsp = '0;
      step_rsp.last = 1'b1;
      unique case (hold_ff.kind)
         gbn_pkg::KIND_SEND: begin
            step_rsp.seq_out = next_ff;
            if (full_now) begin
               step_rsp.event_res = gbn_pkg::EV_REFUSED;
            end else begin
               step_rsp.event_res     = gbn_pkg::EV_NEW;
               step_rsp.data_out      = gbn_pkg::DATA_W'(
                                           hold_ff.payload[gbn_pkg::PAYLOAD_BITS-1:0]);
               step_rsp.timer_command = (base_ff == next_ff) ? gbn_pkg::TMR_START
                                                             : gbn_pkg::TMR_NONE;
               next_new = gbn_pkg::SEQ_W'(next_ff + 1'b1);
               store_we = cmd.step;
            end
         end
         gbn_pkg::KIND_ACK: begin
            if (!hold_ff.ack_intact) begin
               step_rsp.event_res = gbn_pkg::EV_ACK_CORRUPT;
            end else if (ack_off >= outstanding) begin
               step_rsp.event_res = gbn_pkg::EV_ACK_STALE;
            end else begin
               base_new = gbn_pkg::SEQ_W'(hold_ff.ack_number + 1'b1);
               step_rsp.event_res     = gbn_pkg::EV_ACK_TAKEN;
               step_rsp.timer_command = (base_new != next_ff) ? gbn_pkg::TMR_RESTART
                                                              : gbn_pkg::TMR_STOP;
            end
         end
         default: begin
            step_rsp.event_res     = gbn_pkg::EV_TIMEOUT_IDLE;
            step_rsp.timer_command = gbn_pkg::TMR_START;
         end
      endcase
      out_after = gbn_pkg::SEQ_W'(next_new - base_new);
      step_rsp.window_full = out_after >= window_size_ff;
   end

   always_comb begin
      retx_rsp               = '0;
      retx_rsp.event_res     = gbn_pkg::EV_RETX;
      retx_rsp.seq_out       = gbn_pkg::SEQ_W'(base_ff + idx_ff);
      retx_rsp.data_out      = gbn_pkg::DATA_W'(store_rdata);
      retx_rsp.timer_command = (idx_ff == '0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
      retx_rsp.window_full   = full_now;
      retx_rsp.last          = retx_last;
   end

   // retransmit reads run one beat ahead of the output register
   assign store_re    = cmd.retx_start | (cmd.retx_emit & ~retx_last);
   assign store_raddr = cmd.retx_start ? base_ff : gbn_pkg::SEQ_W'(base_ff + idx_ff + 1'b1);

   gbn_ram #(
      .WIDTH(gbn_pkg::PAYLOAD_BITS),
      .DEPTH(gbn_pkg::SEQ_SPACE)
   ) u_store (
      .clock(clock),
      .we   (store_we),
      .waddr(next_ff),
      .wdata(hold_ff.payload[gbn_pkg::PAYLOAD_BITS-1:0]),
      .re   (store_re),
      .raddr(store_raddr),
      .rdata(store_rdata)
   );

   always_comb begin
      base_in = cmd.step ? base_new : base_ff;
      next_in = cmd.step ? next_new : next_ff;
      if (cmd.retx_start) begin
         idx_in = '0;
      end else if (cmd.retx_emit) begin
         idx_in = gbn_pkg::SEQ_W'(idx_ff + 1'b1);
      end else begin
         idx_in = idx_ff;
      end
      hold_in = cmd.hold_load ? req_data : hold_ff;
      if (cmd.retx_emit) begin
         rsp_in = retx_rsp;
      end else if (cmd.step) begin
         rsp_in = step_rsp;
      end else begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= gbn_pkg::WINDOW_RESET;
         base_ff        <= '0;
         next_ff        <= '0;
         idx_ff         <= '0;
      end else begin
         window_size_ff <= window_size_in;
         base_ff        <= base_in;
         next_ff        <= next_in;
         idx_ff         <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign status.kind      = hold_ff.kind;
   assign status.cnt_zero  = (outstanding == '0);
   assign status.retx_last = retx_last;
   assign rsp_data         = rsp_ff;

endmodule

/* hw/rtl/gbn_ctrl.sv */
module gbn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  gbn_pkg::status_type status,
   output gbn_pkg::cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RETX
   } state_type;

   state_type state_ff, state_in;
   logic      hold_valid_ff, hold_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;

      cmd.hold_load = ~hold_valid_ff & req_valid;
      if (cmd.hold_load) begin
         hold_valid_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (hold_valid_ff) begin
               priority if (status.kind == gbn_pkg::KIND_TIMEOUT && !status.cnt_zero) begin
                  cmd.retx_start = 1'b1;
                  state_in       = ST_RETX;
               end else if (status.kind == gbn_pkg::KIND_SEND
                            || status.kind == gbn_pkg::KIND_ACK
                            || status.kind == gbn_pkg::KIND_TIMEOUT) begin
                  if (out_free) begin
                     cmd.step      = 1'b1;
                     rsp_valid_in  = 1'b1;
                     hold_valid_in = 1'b0;
                  end
               end else begin
                  // unused kind: dropped without a result
                  hold_valid_in = 1'b0;
               end
            end
         end
         ST_RETX: begin
            if (out_free) begin
               cmd.retx_emit = 1'b1;
               rsp_valid_in  = 1'b1;
               if (status.retx_last) begin
                  state_in      = ST_IDLE;
                  hold_valid_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_ready = ~hold_valid_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/go_back_n_sender.sv */
// channel   direction  handshake              payload
// req_      in         req_valid/req_ready    gbn_pkg::req_type (kind, payload, ack, intact)
// rsp_      out        rsp_valid/rsp_ready    gbn_pkg::rsp_type (one beat per result)
// APB       in         psel/penable/pwrite    window_size at byte address 0
//
// Each beat is first taken into the holding register; send and ack then produce
// their result, and an unused kind is dropped without a result.
// A timeout with packets outstanding resends them in order from base; the packet
// store has one read port, so retransmits leave one beat per cycle while rsp_ready is high.
// Synchronous reset clears the window to empty and window_size to 4.
// A stall on rsp_ready holds the result register and the store read data.
module go_back_n_sender (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  gbn_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output gbn_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gbn_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gbn_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gbn_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   gbn_pkg::cmd_type    cmd;
   gbn_pkg::status_type status;

   assign pready = 1'b1;

   gbn_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   gbn_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .status  (status),
      .rsp_data(rsp_data),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata)
   );

endmodule

/* hw/rtl/gbn_checker.sv */
module gbn_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gbn_pkg::rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // only retransmit bursts span more than one beat
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res != gbn_pkg::EV_RETX |-> rsp_data.last)
      else $error("non-retransmit result without last");

   a_ack_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == gbn_pkg::EV_ACK_TAKEN
                    || rsp_data.event_res == gbn_pkg::EV_ACK_CORRUPT
                    || rsp_data.event_res == gbn_pkg::EV_ACK_STALE
                    || rsp_data.event_res == gbn_pkg::EV_TIMEOUT_IDLE)
      |-> rsp_data.seq_out == '0 && rsp_data.data_out == '0)
      else $error("ack or idle result carries packet fields");

   // holding register is full right after an accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is held");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (.*);
